### src/nmf_pkg.sv
// shared types and constants of the neighbour median filter
`timescale 1ns / 1ps
`default_nettype none

package nmf_pkg;

   localparam int CFG_W   = 11;
   localparam int PIX_W   = 32;
   localparam int CHAN_W  = 8;
   localparam int RGB_W   = 24;
   localparam int NB      = 8;
   localparam int CNT_W   = 4;

   localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

   // one-hot result selectors, in emission order
   localparam logic [3:0] SEL_MID_LEFT  = 4'b0001;
   localparam logic [3:0] SEL_MID_RIGHT = 4'b0010;
   localparam logic [3:0] SEL_BOT_LEFT  = 4'b0100;
   localparam logic [3:0] SEL_BOT_RIGHT = 4'b1000;

   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic last_col;
      logic last_row;
   } nmf_pos_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic              end_of_run;
      logic              end_of_frame;
   } nmf_meta_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_alpha;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic              end_of_run;
      logic              end_of_frame;
   } nmf_result_type;

endpackage

`default_nettype wire

### src/neighbour_median_filter_3x3_core.sv
// neighbour median filter top level: line buffers, window, result sequencer
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGBA pixel per unstalled cycle in raster order; returns, per color channel, the
// median of the pixel's in-frame neighbours (centre excluded), alpha taken from the centre.
// Results trail the input by about one row. An input normally yields at most one word, so
// the stream runs at one pixel per cycle unless the output stalls; at the last column and along
// the last row one input yields up to four words, one per unstalled cycle, and the next input
// waits until the last is issued. Two line RAMs of MAX_WIDTH entries hold the previous two rows;
// each pixel does one read and one write back per RAM, then passes the window, median stages and
// output register. Frame size comes from the csr registers, clamped to 2..MAX_WIDTH / MAX_HEIGHT.

module neighbour_median_filter_3x3_core
   import nmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [31:0]      req_tdata,   // in_red, in_green, in_blue, in_alpha
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [31:0]      rsp_tdata,   // out_red, out_green, out_blue, out_alpha
   output      logic             rsp_tlast,
   output      logic [0:0]       rsp_tuser,   // end_of_frame
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_addr,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int XWA = $clog2(MAX_WIDTH + 1);
   localparam int YWA = $clog2(MAX_HEIGHT + 1);
   localparam int XW  = (CFG_W > XWA) ? CFG_W : XWA;
   localparam int YW  = (CFG_W > YWA) ? CFG_W : YWA;

   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic             b_valid_ff;
   logic [PIX_W-1:0] b_px_ff;
   logic [CW-1:0]    b_idx_ff;
   nmf_pos_type      b_pos_ff;
   nmf_pos_type      pos_in;

   logic [PIX_W-1:0] win_ff [0:2][0:2];
   logic [3:0]       c_mask_ff, c_mask_in;
   logic             c_top_ff;
   logic             c_left_ff;

   logic             out_valid_ff;
   nmf_result_type   out_word_ff;
   logic             skid_valid_ff;
   nmf_result_type   skid_word_ff;

   logic [PIX_W-1:0] up_rd;
   logic [PIX_W-1:0] mid_rd;
   logic [XW-1:0]    w_eff;
   logic [YW-1:0]    h_eff;
   logic             adv;
   logic             c_last;
   logic             b_go;
   logic             accept;
   logic             issue;
   logic [3:0]       sel;
   logic [3:0]       new_mask;

   logic [NB-1:0][RGB_W-1:0] nb_val;
   logic [NB-1:0]            nb_ok;
   nmf_meta_type             nb_meta;
   logic                     med_valid;
   nmf_result_type           med_word;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (XW'(image_width_ff) < XW'(2)) begin
         w_eff = XW'(2);
      end else if (XW'(image_width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(image_width_ff);
      end
      if (YW'(image_height_ff) < YW'(2)) begin
         h_eff = YW'(2);
      end else if (YW'(image_height_ff) > YW'(MAX_HEIGHT)) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(image_height_ff);
      end
   end

   // handshake and stage control
   assign adv        = !skid_valid_ff;
   assign c_last     = ((c_mask_ff & (c_mask_ff - 4'd1)) == 4'd0);
   assign b_go       = b_valid_ff && adv && c_last;
   assign req_tready = adv && (!b_valid_ff || c_last);
   assign accept     = req_tvalid && req_tready;
   assign issue      = adv && (c_mask_ff != 4'd0);
   assign sel        = c_mask_ff & (~c_mask_ff + 4'd1);

   // position counters
   always_comb begin
      pos_in.r_ge1    = (row_ff != '0);
      pos_in.r_ge2    = (RW'(row_ff) >= RW'(2)) && (MAX_HEIGHT > 2);
      pos_in.c_ge1    = (col_ff != '0);
      pos_in.c_ge2    = (CW'(col_ff) >= CW'(2)) && (MAX_WIDTH > 2);
      pos_in.last_col = (XW'(col_ff) >= (w_eff - XW'(1)));
      pos_in.last_row = (YW'(row_ff) >= (h_eff - YW'(1)));
      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (pos_in.last_col) begin
         col_in = '0;
         row_in = pos_in.last_row ? '0 : row_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         b_px_ff  <= req_tdata;
         b_idx_ff <= col_ff;
         b_pos_ff <= pos_in;
      end
   end

   // line buffers: read at accept, write back when the pixel enters the window
   nmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock (clock),
      .we    (b_go),
      .waddr (b_idx_ff),
      .wdata (mid_rd),
      .re    (accept),
      .raddr (col_ff),
      .rdata (up_rd)
   );

   nmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock (clock),
      .we    (b_go),
      .waddr (b_idx_ff),
      .wdata (b_px_ff),
      .re    (accept),
      .raddr (col_ff),
      .rdata (mid_rd)
   );

   // window shift and result sequencer
   always_comb begin
      new_mask = '0;
      if (b_pos_ff.r_ge1) begin
         new_mask[0] = b_pos_ff.c_ge1;
         new_mask[1] = b_pos_ff.last_col;
         new_mask[2] = b_pos_ff.last_row && b_pos_ff.c_ge1;
         new_mask[3] = b_pos_ff.last_row && b_pos_ff.last_col;
      end
      c_mask_in = c_mask_ff;
      if (b_go) begin
         c_mask_in = new_mask;
      end else if (issue) begin
         c_mask_in = c_mask_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_mask_ff <= '0;
      end else begin
         c_mask_ff <= c_mask_in;
      end
      if (b_go) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= up_rd;
         win_ff[1][2] <= mid_rd;
         win_ff[2][2] <= b_px_ff;
         c_top_ff     <= b_pos_ff.r_ge2;
         c_left_ff    <= b_pos_ff.c_ge2;
      end
   end

   // neighbour gather for the selected centre
   always_comb begin
      int   wr;
      int   wc;
      int   rr;
      int   cc;
      int   k;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic okv;
      wr = 1;
      wc = 1;
      top = c_top_ff;
      bottom = 1'b1;
      left = c_left_ff;
      right = 1'b1;
      case (sel)
         SEL_MID_LEFT: begin
            wr = 1; wc = 1; top = c_top_ff; bottom = 1'b1; left = c_left_ff; right = 1'b1;
         end
         SEL_MID_RIGHT: begin
            wr = 1; wc = 2; top = c_top_ff; bottom = 1'b1; left = 1'b1; right = 1'b0;
         end
         SEL_BOT_LEFT: begin
            wr = 2; wc = 1; top = 1'b1; bottom = 1'b0; left = c_left_ff; right = 1'b1;
         end
         SEL_BOT_RIGHT: begin
            wr = 2; wc = 2; top = 1'b1; bottom = 1'b0; left = 1'b1; right = 1'b0;
         end
         default: ;
      endcase
      k = 0;
      nb_val = '0;
      nb_ok = '0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (!(dr == 0 && dc == 0)) begin
               rr = wr + dr;
               cc = wc + dc;
               okv = ((dr < 0) ? top : ((dr > 0) ? bottom : 1'b1)) &&
                     ((dc < 0) ? left : ((dc > 0) ? right : 1'b1)) &&
                     (rr <= 2) && (cc <= 2);
               nb_ok[k] = okv;
               if (okv) begin
                  nb_val[k] = win_ff[rr[1:0]][cc[1:0]][RGB_W-1:0];
               end
               k = k + 1;
            end
         end
      end
      nb_meta.alpha        = win_ff[wr[1:0]][wc[1:0]][PIX_W-1:RGB_W];
      nb_meta.end_of_run   = c_last;
      nb_meta.end_of_frame = (sel == SEL_BOT_RIGHT);
   end

   nmf_median u_median (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (issue),
      .in_val    (nb_val),
      .in_ok     (nb_ok),
      .in_meta   (nb_meta),
      .out_valid (med_valid),
      .out_word  (med_word)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= med_valid;
         end
      end else if (med_valid && adv) begin
         skid_valid_ff <= 1'b1;
      end
      if (!out_valid_ff || rsp_tready) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : med_word;
      end else if (med_valid && adv) begin
         skid_word_ff <= med_word;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_word_ff.out_alpha, out_word_ff.out_blue,
                          out_word_ff.out_green, out_word_ff.out_red};
   assign rsp_tlast    = out_word_ff.end_of_run;
   assign rsp_tuser[0] = out_word_ff.end_of_frame;

endmodule

`default_nettype wire

### src/nmf_ram.sv
// generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none

module nmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/nmf_median.sv
// two-stage rank-select median of up to eight neighbours, three channels
`timescale 1ns / 1ps
`default_nettype none

module nmf_median
   import nmf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [NB-1:0][RGB_W-1:0]  in_val,
   input  wire logic [NB-1:0]             in_ok,
   input  wire nmf_meta_type              in_meta,
   output      logic                      out_valid,
   output      nmf_result_type            out_word
);

   logic                     s1_valid_ff;
   logic [NB-1:0][RGB_W-1:0] s1_val_ff;
   logic [NB-1:0]            s1_ok_ff;
   nmf_meta_type             s1_meta_ff;

   logic                     s2_valid_ff;
   logic [NB-1:0][RGB_W-1:0] s2_val_ff;
   logic [NB-1:0]            s2_ok_ff;
   logic [CNT_W-1:0]         s2_target_ff;
   nmf_meta_type             s2_meta_ff;
   logic [2:0][NB-1:0][NB-1:0] s2_before_ff;

   logic [2:0][NB-1:0][NB-1:0] before_in;
   logic [CNT_W-1:0]           target_in;
   logic [2:0][CHAN_W-1:0]     med;

   always_comb begin
      logic [CHAN_W-1:0] vi;
      logic [CHAN_W-1:0] vj;
      logic [CNT_W-1:0]  cnt;
      cnt = '0;
      for (int j = 0; j < NB; j++) begin
         cnt = cnt + CNT_W'(s1_ok_ff[j]);
      end
      target_in = cnt >> 1;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < NB; i++) begin
            for (int j = 0; j < NB; j++) begin
               vi = s1_val_ff[i][ch*CHAN_W +: CHAN_W];
               vj = s1_val_ff[j][ch*CHAN_W +: CHAN_W];
               before_in[ch][i][j] = s1_ok_ff[j] && ((vj < vi) || ((vj == vi) && (j < i)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s1_val_ff    <= in_val;
         s1_ok_ff     <= in_ok;
         s1_meta_ff   <= in_meta;
         s2_val_ff    <= s1_val_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_target_ff <= target_in;
         s2_meta_ff   <= s1_meta_ff;
         s2_before_ff <= before_in;
      end
   end

   // exactly one valid neighbour has rank equal to the target
   always_comb begin
      logic [CNT_W-1:0] rank;
      med = '0;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < NB; i++) begin
            rank = '0;
            for (int j = 0; j < NB; j++) begin
               rank = rank + CNT_W'(s2_before_ff[ch][i][j]);
            end
            if (s2_ok_ff[i] && (rank == s2_target_ff)) begin
               med[ch] = med[ch] | s2_val_ff[i][ch*CHAN_W +: CHAN_W];
            end
         end
      end
   end

   assign out_valid              = s2_valid_ff;
   assign out_word.out_red       = med[0];
   assign out_word.out_green     = med[1];
   assign out_word.out_blue      = med[2];
   assign out_word.out_alpha     = s2_meta_ff.alpha;
   assign out_word.end_of_run    = s2_meta_ff.end_of_run;
   assign out_word.end_of_frame  = s2_meta_ff.end_of_frame;

endmodule

`default_nettype wire

### src/nmf_checker.sv
// port-level checks of the neighbour median filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module nmf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [0:0]  rsp_tuser
);

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("end of frame without end of run");

endmodule

bind neighbour_median_filter_3x3_core nmf_checker u_nmf_checker (.*);

`default_nettype wire
